/* hw/rtl/key_scan_press_and_hold_tracker_defines.svh */
// assertion helpers for the key scan tracker checkers
`ifndef KEY_SCAN_PRESS_AND_HOLD_TRACKER_DEFINES_SVH
`define KEY_SCAN_PRESS_AND_HOLD_TRACKER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define KSHT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define KSHT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/ksht_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksht_pkg
// Shared constants, scan bit map and lane result type for the key scan
// press and hold tracker.
// ----------------------------------------------------------------------------
package ksht_pkg;

  localparam int OUT_W       = 16;
  localparam int TABLE_SIZE  = 16;
  localparam int CNT_W       = 8;
  localparam int DEF_BUTTONS = 16;

  localparam logic [CNT_W-1:0] HOLD_RESET = 8'd100;

  // scan word bit that drives each button
  localparam logic [4:0] SCAN_BIT [TABLE_SIZE] = '{
    5'd31, 5'd28, 5'd26, 5'd10, 5'd29, 5'd30, 5'd24, 5'd25,
    5'd27, 5'd16, 5'd0,  5'd9,  5'd19, 5'd18, 5'd17, 5'd1
  };

  typedef struct packed {
    logic pressed;
    logic rise;
    logic long_hit;
  } lane_res_t;

endpackage

/* hw/rtl/ksht_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksht_lane
// One button slice: picks its scan bit, keeps the held-scan count and the
// previous pressed bit, and reports press, rising edge and long press.
// ----------------------------------------------------------------------------
module ksht_lane import ksht_pkg::*; #(
  parameter int LANE_IDX = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [31:0]      scan_word,
  input  logic [CNT_W-1:0] threshold,
  output lane_res_t        res
);

  logic             hit;
  logic             prev;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_inc;
  logic [CNT_W-1:0] count_next;
  logic             over;

  generate
    if (LANE_IDX < TABLE_SIZE) begin : g_mapped
      assign hit = scan_word[SCAN_BIT[LANE_IDX]];
    end else begin : g_unmapped
      assign hit = 1'b0;
    end
  endgenerate

  // count wraps within its width
  assign count_inc  = count + 1'b1;
  assign over       = hit && (count_inc > threshold);
  assign count_next = !hit ? count : (over ? '0 : count_inc);

  assign res.pressed  = hit;
  assign res.rise     = hit & ~prev;
  assign res.long_hit = over;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      prev  <= 1'b0;
    end else if (accept) begin
      count <= count_next;
      prev  <= hit;
    end
  end

endmodule

/* hw/rtl/ksht_merge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksht_merge
// Combines the lane results: per-button LED toggles, long-press LED parity
// toggle, and the registered result with its valid flag.
// ----------------------------------------------------------------------------
module ksht_merge import ksht_pkg::*; #(
  parameter int NUM_BUTTONS = DEF_BUTTONS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic              take,
  input  lane_res_t         res [NUM_BUTTONS],
  output logic              result_valid,
  output logic [OUT_W-1:0]  button_state,
  output logic [OUT_W-1:0]  press_edges,
  output logic [OUT_W-1:0]  led_states,
  output logic              long_press_led
);

  logic [NUM_BUTTONS-1:0] pressed;
  logic [NUM_BUTTONS-1:0] rises;
  logic [NUM_BUTTONS-1:0] hits;
  logic [NUM_BUTTONS-1:0] led_bits;
  logic [NUM_BUTTONS-1:0] led_bits_next;
  logic                   long_led;
  logic                   long_led_next;
  logic [OUT_W-1:0]       pressed_w;
  logic [OUT_W-1:0]       rises_w;
  logic [OUT_W-1:0]       leds_w;

  generate
    for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_gather
      assign pressed[b] = res[b].pressed;
      assign rises[b]   = res[b].rise;
      assign hits[b]    = res[b].long_hit;
    end
    for (genvar i = 0; i < OUT_W; i++) begin : g_out
      if (i < NUM_BUTTONS) begin : g_used
        assign pressed_w[i] = pressed[i];
        assign rises_w[i]   = rises[i];
        assign leds_w[i]    = led_bits_next[i];
      end else begin : g_pad
        assign pressed_w[i] = 1'b0;
        assign rises_w[i]   = 1'b0;
        assign leds_w[i]    = 1'b0;
      end
    end
  endgenerate

  assign led_bits_next = led_bits ^ rises;
  // one toggle per lane that passed threshold
  assign long_led_next = long_led ^ (^hits);

  always_ff @(posedge clk) begin
    if (rst) begin
      led_bits     <= '0;
      long_led     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        led_bits     <= led_bits_next;
        long_led     <= long_led_next;
        result_valid <= 1'b1;
      end else if (take) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      button_state   <= pressed_w;
      press_edges    <= rises_w;
      led_states     <= leds_w;
      long_press_led <= long_led_next;
    end
  end

endmodule

/* hw/rtl/key_scan_press_and_hold_tracker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_scan_press_and_hold_tracker
// Key matrix scan decoder with press-edge LED toggles and long-press detect.
// ----------------------------------------------------------------------------
// Takes one 32-bit scan word per transfer and returns one result per scan,
// in the next cycle, at a sustained rate of one scan per clock. All button
// lanes update their held counts and previous-press bits in the cycle of the
// transfer, and the merge stage registers the result; the input stalls only
// while that result register is full and the output side is stalling.
// hold_threshold may be written only while no scan is in flight.
module key_scan_press_and_hold_tracker import ksht_pkg::*; #(
  parameter int NUM_BUTTONS = DEF_BUTTONS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [CNT_W-1:0] cfg_data,
  input  logic             scan_valid,
  output logic             scan_stall,
  input  logic [31:0]      scan_word,
  output logic             result_valid,
  input  logic             result_stall,
  output logic [OUT_W-1:0] button_state,
  output logic [OUT_W-1:0] press_edges,
  output logic [OUT_W-1:0] led_states,
  output logic             long_press_led
);

  logic             hold_threshold;
  logic [CNT_W-1:0] threshold;
  logic             accept;
  logic             take;
  lane_res_t        res [NUM_BUTTONS];

  assign hold_threshold = cfg_write;
  assign scan_stall     = result_valid & result_stall;
  assign accept         = scan_valid & ~scan_stall;
  assign take           = result_valid & ~result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= HOLD_RESET;
    end else if (hold_threshold) begin
      threshold <= cfg_data;
    end
  end

  generate
    for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
      ksht_lane #(
        .LANE_IDX (b)
      ) u_lane (
        .clk       (clk),
        .rst       (rst),
        .accept    (accept),
        .scan_word (scan_word),
        .threshold (threshold),
        .res       (res[b])
      );
    end
  endgenerate

  ksht_merge #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_merge (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .take           (take),
    .res            (res),
    .result_valid   (result_valid),
    .button_state   (button_state),
    .press_edges    (press_edges),
    .led_states     (led_states),
    .long_press_led (long_press_led)
  );

endmodule

/* hw/rtl/ksht_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksht_checker
// Port-level checks for the key scan tracker, bound to the top level.
// ----------------------------------------------------------------------------
`include "key_scan_press_and_hold_tracker_defines.svh"

module ksht_checker import ksht_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             scan_valid,
  input logic             scan_stall,
  input logic             result_valid,
  input logic             result_stall,
  input logic [OUT_W-1:0] button_state,
  input logic [OUT_W-1:0] press_edges,
  input logic [OUT_W-1:0] led_states,
  input logic             long_press_led
);

  // a rising edge implies the button is pressed now
  `KSHT_ASSERT_NOW(a_edge_pressed, result_valid, (press_edges & ~button_state) == '0, "edge without press")

  // input stalls only behind a full, stalled result register
  `KSHT_ASSERT_NOW(a_stall_cause, scan_stall, result_valid && result_stall, "spurious input stall")

  // every scan transfer yields a result next cycle
  `KSHT_ASSERT_NEXT(a_result_follows, scan_valid && !scan_stall, result_valid, "result missing")

  // stalled result holds
  `KSHT_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(led_states) && $stable(long_press_led), "stalled result changed")

endmodule

bind key_scan_press_and_hold_tracker ksht_checker u_checker (.*);

/* test/ksht_scan_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksht_scan_checker
// Watches the scan and result channels of the key scan tracker, tracks button
// state, held counts and both LED registers, and compares every result.
// ----------------------------------------------------------------------------
module ksht_scan_checker import ksht_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [CNT_W-1:0] cfg_data,
  input  logic             scan_valid,
  input  logic             scan_stall,
  input  logic [31:0]      scan_word,
  input  logic             result_valid,
  input  logic             result_stall,
  input  logic [OUT_W-1:0] button_state,
  input  logic [OUT_W-1:0] press_edges,
  input  logic [OUT_W-1:0] led_states,
  input  logic             long_press_led,
  output int               fail_count,
  output int               outstanding
);

  typedef struct packed {
    logic [15:0] buttons;
    logic [15:0] edges;
    logic [15:0] leds;
    logic        long_led;
  } scan_result_t;

  // scan word bit selected by each button
  localparam logic [31:0] BUTTON_MASK [16] = '{
    32'h8000_0000, 32'h1000_0000, 32'h0400_0000, 32'h0000_0400,
    32'h2000_0000, 32'h4000_0000, 32'h0100_0000, 32'h0200_0000,
    32'h0800_0000, 32'h0001_0000, 32'h0000_0001, 32'h0000_0200,
    32'h0008_0000, 32'h0004_0000, 32'h0002_0000, 32'h0000_0002
  };

  scan_result_t expected_results[$];
  logic [7:0]   hold_limit;
  logic [15:0]  last_buttons;
  logic [7:0]   held_scans [16];
  logic [15:0]  led_reg;
  logic         long_led_reg;

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    scan_result_t want;
    logic [15:0]  now;
    if (rst) begin
      hold_limit   = 8'd100;
      last_buttons = '0;
      led_reg      = '0;
      long_led_reg = 1'b0;
      for (int b = 0; b < 16; b++) held_scans[b] = '0;
      expected_results.delete();
    end else begin
      if (cfg_write) hold_limit = cfg_data;

      // results first: a scan accepted at this edge cannot come out at it
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with nothing expected: button_state %h", button_state);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (button_state !== want.buttons) begin
            $error("button_state: expected %h, actual %h", want.buttons, button_state);
            fail_count++;
          end
          if (press_edges !== want.edges) begin
            $error("press_edges: expected %h, actual %h", want.edges, press_edges);
            fail_count++;
          end
          if (led_states !== want.leds) begin
            $error("led_states: expected %h, actual %h", want.leds, led_states);
            fail_count++;
          end
          if (long_press_led !== want.long_led) begin
            $error("long_press_led: expected %b, actual %b", want.long_led, long_press_led);
            fail_count++;
          end
        end
      end

      if (scan_valid && !scan_stall) begin
        now = '0;
        for (int b = 0; b < 16; b++) begin
          if (|(scan_word & BUTTON_MASK[b])) begin
            now[b] = 1'b1;
            held_scans[b] = held_scans[b] + 8'd1;
            if (held_scans[b] > hold_limit) begin
              held_scans[b] = '0;
              long_led_reg  = ~long_led_reg;
            end
          end
        end
        want.buttons = now;
        want.edges   = now & ~last_buttons;
        led_reg      = led_reg ^ want.edges;
        last_buttons = now;
        want.leds     = led_reg;
        want.long_led = long_led_reg;
        expected_results.push_back(want);
      end
    end
    outstanding <= expected_results.size();
  end

endmodule

/* test/tb_key_scan_press_and_hold_tracker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_key_scan_press_and_hold_tracker
// Drives scan words through the key scan tracker under random gaps and
// output stalls, over several hold thresholds including 0 and 255, while a
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_key_scan_press_and_hold_tracker;
  import ksht_pkg::*;

  logic             clk;
  logic             rst = 1'b1;
  logic             cfg_write = 1'b0;
  logic [CNT_W-1:0] cfg_data = '0;
  logic             scan_valid = 1'b0;
  logic             scan_stall;
  logic [31:0]      scan_word = '0;
  logic             result_valid;
  logic             result_stall = 1'b0;
  logic [OUT_W-1:0] button_state;
  logic [OUT_W-1:0] press_edges;
  logic [OUT_W-1:0] led_states;
  logic             long_press_led;

  int          fail_count;
  int          outstanding;
  logic        quiet = 1'b0;
  int          mode_left = 0;
  int          stall_left = 0;
  int          stall_pick;
  logic [31:0] mapped_bits;
  logic [15:0] held_mask;

  key_scan_press_and_hold_tracker u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .scan_valid     (scan_valid),
    .scan_stall     (scan_stall),
    .scan_word      (scan_word),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .button_state   (button_state),
    .press_edges    (press_edges),
    .led_states     (led_states),
    .long_press_led (long_press_led)
  );

  ksht_scan_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .scan_valid     (scan_valid),
    .scan_stall     (scan_stall),
    .scan_word      (scan_word),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .button_state   (button_state),
    .press_edges    (press_edges),
    .led_states     (led_states),
    .long_press_led (long_press_led),
    .fail_count     (fail_count),
    .outstanding    (outstanding)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // quiet stretches: no gaps and no stalls for a while
  always @(posedge clk) begin
    if (mode_left == 0) begin
      quiet     <= ($urandom_range(0, 3) == 0);
      mode_left <= $urandom_range(40, 250);
    end else begin
      mode_left <= mode_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst || (quiet && stall_left == 0)) begin
      result_stall <= 1'b0;
    end else if (stall_left != 0) begin
      result_stall <= 1'b1;
      stall_left   <= stall_left - 1;
    end else begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 65) begin
        result_stall <= 1'b0;
      end else if (stall_pick < 95) begin
        result_stall <= 1'b1;
        stall_left   <= $urandom_range(0, 2);
      end else begin
        result_stall <= 1'b1;
        stall_left   <= $urandom_range(9, 39);
      end
    end
  end

  function automatic logic [31:0] scan_of(input logic [15:0] buttons);
    logic [31:0] w;
    w = '0;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      if (buttons[i]) w[SCAN_BIT[i]] = 1'b1;
    end
    return w;
  endfunction

  task automatic send_scan(input logic [31:0] w);
    int pick;
    int gap;
    scan_valid <= 1'b1;
    scan_word  <= w;
    do @(posedge clk); while (scan_stall);
    pick = $urandom_range(0, 99);
    if (quiet || pick < 60) gap = 0;
    else if (pick < 95) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap > 0) begin
      scan_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    int spins;
    spins = 0;
    scan_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (outstanding != 0 && spins < 5000) begin
      @(posedge clk);
      spins++;
    end
    repeat (4) @(posedge clk);
  endtask

  // mostly held buttons that change slowly, with noise on unused scan bits
  task automatic send_random_scans(input int count);
    int          pick;
    logic [31:0] w;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        w = $urandom();
      end else begin
        if ($urandom_range(0, 15) == 0) held_mask[$urandom_range(0, 15)] ^= 1'b1;
        w = scan_of(held_mask) | ($urandom() & ~mapped_bits);
        if (pick < 30) w = w ^ scan_of(16'(1 << $urandom_range(0, 15)));
      end
      send_scan(w);
    end
  endtask

  initial begin
    logic [7:0] limits [8];
    int         counts [8];
    mapped_bits = scan_of(16'hFFFF);
    held_mask   = 16'(($urandom()));
    limits = '{8'd100, 8'd0, 8'd1, 8'd255, 8'd254, 8'd2,
               8'($urandom_range(3, 253)), 8'($urandom_range(3, 253))};
    counts = '{100, 90, 90, 280, 110, 60, 60, 60};

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed scans at the reset threshold
    send_scan(32'h0000_0000);
    send_scan(32'hFFFF_FFFF);
    send_scan(~mapped_bits);
    for (int i = 0; i < 16; i++) send_scan(scan_of(16'(1 << i)));
    send_scan(32'hAAAA_AAAA);
    send_scan(32'h5555_5555);
    send_scan(32'h0000_0000);

    for (int p = 0; p < 8; p++) begin
      if (p > 0) begin
        drain_results();
        cfg_write <= 1'b1;
        cfg_data  <= limits[p];
        @(posedge clk);
        cfg_write <= 1'b0;
      end
      send_random_scans(counts[p]);
    end

    drain_results();
    if (fail_count == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
